>>> rtl/bmh_pkg.sv
// ============================================================================
// bmh_pkg: shared types and constants of the binary min-heap
// Key type, item mode codes, result status codes and the result word passed
// from the controller to the output stage.
// ============================================================================
package bmh_pkg;

    localparam int KEY_W     = 32;
    localparam int CNT_W     = 10;
    localparam int STATUS_W  = 2;
    localparam int OUT_TDATA_W = ((KEY_W + CNT_W + 7) / 8) * 8;

    // Item mode carried in the input tuser bit.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_key               key;
        t_status            status;
        logic [CNT_W-1:0]   count;
    } t_result;

endpackage

>>> rtl/bmh_ram.sv
// ============================================================================
// bmh_ram: key storage of the heap
// One write port and two read ports; read data is registered, so it
// appears in the cycle after the address.
// ============================================================================
module bmh_ram
    import bmh_pkg::*;
#(
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_key          i_wdata,
    input  logic [AW-1:0] i_ra_addr,
    input  logic [AW-1:0] i_rb_addr,
    output t_key          o_rd_a,
    output t_key          o_rd_b
);

    t_key mem [DEPTH];
    t_key r_rd_a;
    t_key r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= mem[i_ra_addr];
        r_rd_b <= mem[i_rb_addr];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

>>> rtl/bmh_ctrl.sv
// ============================================================================
// bmh_ctrl: heap sequencer
// Walks sift-up and sift-down one level per cycle against the key RAM and
// holds the finished result until the output stage takes it.
// ============================================================================
module bmh_ctrl
    import bmh_pkg::*;
#(
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // item side
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_mode,
    input  t_key          i_key,
    // key RAM
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output t_key          o_wdata,
    output logic [AW-1:0] o_ra_addr,
    output logic [AW-1:0] o_rb_addr,
    input  t_key          i_rd_a,
    input  t_key          i_rd_b,
    // result side
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output t_result       o_res
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_INS_CMP  = 6'b000010,
        S_PUT      = 6'b000100,
        S_REM_LOAD = 6'b001000,
        S_REM_CMP  = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    localparam logic [AW-1:0] CNT_FULL = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROOT     = AW'(1);

    t_state        r_state,   n_state;
    logic [AW-1:0] r_count,   n_count;
    logic [AW-1:0] r_pos,     n_pos;
    logic [AW:0]   r_child,   n_child;
    t_key          r_key,     n_key;
    t_key          r_res_key, n_res_key;
    t_status       r_status,  n_status;

    logic [AW-1:0] count_inc;
    logic [AW-1:0] up_pos;
    logic [AW:0]   count_ext;
    logic          right_ok;
    logic [AW:0]   pick_idx;
    t_key          pick_key;
    logic [AW:0]   nc_right;

    assign count_inc = r_count + 1'b1;
    assign up_pos    = r_pos >> 1;
    assign count_ext = {1'b0, r_count};
    assign right_ok  = (r_child < count_ext);

    // Right child wins only when strictly smaller than the left one.
    always_comb begin
        if (right_ok && (i_rd_a > i_rd_b)) begin
            pick_idx = r_child + 1'b1;
            pick_key = i_rd_b;
        end else begin
            pick_idx = r_child;
            pick_key = i_rd_a;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_child   = r_child;
        n_key     = r_key;
        n_res_key = r_res_key;
        n_status  = r_status;
        o_we      = 1'b0;
        o_waddr   = r_pos;
        o_wdata   = r_key;
        o_ra_addr = '0;
        o_rb_addr = '0;
        nc_right  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_res_key = '0;
                    n_status  = ST_OK;
                    if (i_mode == MODE_INSERT) begin
                        if (r_count >= CNT_FULL) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_count = count_inc;
                            n_pos   = count_inc;
                            n_key   = i_key;
                            if (r_count == '0) begin
                                o_we    = 1'b1;
                                o_waddr = ROOT;
                                o_wdata = i_key;
                                n_state = S_DONE;
                            end else begin
                                o_ra_addr = count_inc >> 1;
                                n_state   = S_INS_CMP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_count   = r_count - 1'b1;
                            o_ra_addr = ROOT;
                            o_rb_addr = r_count;
                            n_state   = S_REM_LOAD;
                        end
                    end
                end
            end
            S_INS_CMP: begin
                o_we = 1'b1;
                if (r_key < i_rd_a) begin
                    // Parent moves down into the hole, the hole moves up.
                    o_wdata = i_rd_a;
                    n_pos   = up_pos;
                    if (up_pos == ROOT) begin
                        n_state = S_PUT;
                    end else begin
                        o_ra_addr = up_pos >> 1;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PUT: begin
                o_we    = 1'b1;
                n_state = S_DONE;
            end
            S_REM_LOAD: begin
                n_res_key = i_rd_a;
                n_key     = i_rd_b;
                n_pos     = ROOT;
                n_child   = (AW+1)'(2);
                nc_right  = (AW+1)'(3);
                if (n_child <= count_ext) begin
                    o_ra_addr = n_child[AW-1:0];
                    o_rb_addr = (n_child < count_ext) ? nc_right[AW-1:0] : n_child[AW-1:0];
                    n_state   = S_REM_CMP;
                end else begin
                    o_we    = 1'b1;
                    o_waddr = ROOT;
                    o_wdata = i_rd_b;
                    n_state = S_DONE;
                end
            end
            S_REM_CMP: begin
                o_we = 1'b1;
                if (r_key <= pick_key) begin
                    n_state = S_DONE;
                end else begin
                    // Smaller child moves up, the hole moves down.
                    o_wdata  = pick_key;
                    n_pos    = pick_idx[AW-1:0];
                    n_child  = {pick_idx[AW-1:0], 1'b0};
                    nc_right = {pick_idx[AW-1:0], 1'b1};
                    if (n_child <= count_ext) begin
                        o_ra_addr = n_child[AW-1:0];
                        o_rb_addr = (n_child < count_ext) ? nc_right[AW-1:0]
                                                           : n_child[AW-1:0];
                    end else begin
                        n_state = S_PUT;
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos     <= n_pos;
        r_child   <= n_child;
        r_key     <= n_key;
        r_res_key <= n_res_key;
        r_status  <= n_status;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{key: r_res_key, status: r_status, count: CNT_W'(r_count)};

endmodule

>>> rtl/binary_min_heap.sv
// ============================================================================
// binary_min_heap: min-heap priority queue of signed 32-bit keys
// Stream-in insert/remove words, stream-out one result word per item.
// ============================================================================
// The heap holds up to DEPTH-1 signed keys in a single-write, dual-read RAM
// with the root at address 1. A word with tuser = 0 inserts its key; a word
// with tuser = 1 removes and returns the smallest key. Every input word gives
// exactly one output word with the removed key (zero for inserts and errors),
// a status (ok, remove on empty heap, insert on full heap dropped) and the
// number of keys held afterwards. One item is processed at a time: the
// sequencer walks the tree one level per cycle, reading both children of a
// node in one RAM access and writing the moved key back in the next cycle.
// Each item ends in a done state in which the finished result is handed to
// the output register. The output register lets a finished result wait for
// the sink while the next input word is already being worked on. Equal keys
// keep insertion order toward the root, and on a tie between children the
// left child is taken. The key RAM needs no clearing pass; only the key
// count, the sequencer state and the output valid flag are reset.
// ============================================================================
module binary_min_heap
    import bmh_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [KEY_W-1:0]       s_axis_tdata,   // [31:0] key_in
    input  logic [0:0]             s_axis_tuser,   // [0] mode (0 insert, 1 remove)
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [31:0] key_out, [41:32] count
    output logic [STATUS_W-1:0]    m_axis_tuser    // [1:0] status
);

    localparam int AW = $clog2(DEPTH);

    logic          we;
    logic [AW-1:0] waddr;
    t_key          wdata;
    logic [AW-1:0] ra_addr;
    logic [AW-1:0] rb_addr;
    t_key          rd_a;
    t_key          rd_b;

    logic          res_valid;
    logic          res_ready;
    t_result       res;

    logic          r_out_valid;
    t_result       r_out;

    bmh_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_ra_addr (ra_addr),
        .i_rb_addr (rb_addr),
        .o_rd_a    (rd_a),
        .o_rd_b    (rd_b)
    );

    bmh_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_mode      (s_axis_tuser[0]),
        .i_key       (s_axis_tdata),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_ra_addr   (ra_addr),
        .o_rb_addr   (rb_addr),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // The output register is free when empty or when its word leaves now.
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out.count, r_out.key});
    assign m_axis_tuser  = r_out.status;

endmodule

>>> rtl/bmh_chk.sv
// ============================================================================
// bmh_chk: port-level checks of the binary min-heap
// Watches both stream sides of the top level; attached by bind.
// ============================================================================
module bmh_chk
    import bmh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic [STATUS_W-1:0]    i_m_tuser
);

    // No result word may be pending right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output word valid after reset");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
                                      && $stable(i_m_tuser))
        else $error("stalled output word changed");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tuser == ST_OK || i_m_tuser == ST_EMPTY
                        || i_m_tuser == ST_FULL))
        else $error("undefined status code");

    // Error results carry a zero key.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser != ST_OK |-> i_m_tdata[KEY_W-1:0] == '0)
        else $error("error result with nonzero key");

    // One item at a time: an accepted word closes the input in the next cycle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input accepted while an item is in work");

endmodule

bind binary_min_heap bmh_chk u_bmh_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

>>> dv/binary_min_heap_test.sv
`timescale 1ns / 1ps
// ============================================================================
// binary_min_heap_test: self-checking bench for the min-heap priority queue
// Sends insert and remove words through the input stream and checks every
// output word against a behavioral heap kept inside the bench. A short
// directed table covers the extremes, the empty heap and equal keys. Random
// traffic then churns a small heap, fills the heap until inserts are dropped
// as full, and ends with a stretch of back-to-back traffic.
// ============================================================================
module binary_min_heap_test;
    import bmh_pkg::*;

    localparam int   DEPTH        = 1024;
    localparam int   MAX_KEYS     = DEPTH - 1;
    localparam int   LONG_HOLD    = 300;    // cycles the sink refuses words once
    localparam int   TAIL_CYCLES  = 40;     // idle cycles run after every result is back
    localparam int   FILL_CAP     = 2000;   // bound on the fill phase

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [KEY_W-1:0]       s_axis_tdata;   // [31:0] key_in
    logic [0:0]             s_axis_tuser;   // [0] mode (0 insert, 1 remove)
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [31:0] key_out, [41:32] count
    logic [STATUS_W-1:0]    m_axis_tuser;   // [1:0] status

    // One row of the directed table. When known is set the expected word is
    // the one typed in the row; otherwise the heap model supplies it.
    typedef struct {
        logic    mode;
        t_key    key;
        bit      known;
        t_result want;
    } t_stim_row;

    t_key      heap_keys [DEPTH];
    int        heap_size;
    t_result   pending_results [$];
    t_stim_row directed_rows [$];
    t_result   oldest;

    int mismatch_count;
    int results_seen;
    bit calm;
    bit hold_done;
    int full_hits;
    int fill_words;
    int wait_cycles;

    binary_min_heap #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Behavioral heap: root at index 1, insert sifts up while strictly smaller
    // than the parent, remove sifts the last key down and takes the right
    // child only when it is strictly smaller than the left one.
    function automatic t_result predict_heap_result(input logic mode, input t_key key);
        t_result r;
        int      pos;
        int      parent;
        int      child;
        t_key    last;
        r.key    = '0;
        r.status = ST_OK;
        if (mode == MODE_INSERT) begin
            if (heap_size >= MAX_KEYS) begin
                r.status = ST_FULL;
            end else begin
                heap_size++;
                pos = heap_size;
                while (pos != 1 && key < heap_keys[pos / 2]) begin
                    heap_keys[pos] = heap_keys[pos / 2];
                    pos = pos / 2;
                end
                heap_keys[pos] = key;
            end
        end else if (heap_size == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.key  = heap_keys[1];
            last   = heap_keys[heap_size];
            heap_size--;
            parent = 1;
            child  = 2;
            while (child <= heap_size) begin
                if (child < heap_size && heap_keys[child] > heap_keys[child + 1]) begin
                    child++;
                end
                if (last <= heap_keys[child]) break;
                heap_keys[parent] = heap_keys[child];
                parent = child;
                child  = 2 * parent;
            end
            heap_keys[parent] = last;
        end
        r.count = CNT_W'(heap_size);
        return r;
    endfunction

    // Mix of full-range keys, a narrow band that makes many equal keys, and
    // values at or next to both ends of the signed range.
    function automatic t_key pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_key'($urandom);
            4, 5, 6:    return t_key'(int'($urandom_range(0, 16)) - 8);
            7:          return t_key'(32'h7FFF_FFFF - $urandom_range(0, 3));
            8:          return t_key'(32'h8000_0000 + $urandom_range(0, 3));
            default:    return ($urandom_range(0, 1) != 0) ? t_key'(0) : t_key'(-1);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("mismatch at result %0d: %s got %0h want %0h",
                     results_seen, what, got, want);
        end
    endtask

    task automatic add_row(input logic mode, input t_key key, input bit known,
                           input t_key want_key, input t_status want_status,
                           input int want_count);
        t_stim_row row;
        row.mode        = mode;
        row.key         = key;
        row.known       = known;
        row.want.key    = want_key;
        row.want.status = want_status;
        row.want.count  = CNT_W'(want_count);
        directed_rows   = {directed_rows, row};
    endtask

    // Offers one word, waits for it to be taken, then records what must come
    // back. Valid stays high into the next word unless an idle burst follows.
    task automatic send_word(input logic mode, input t_key key, input bit known,
                             input t_result want);
        t_result predicted;
        int      gap;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = key;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_heap_result(mode, key);
        pending_results = {pending_results, (known ? want : predicted)};
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = $urandom;
            s_axis_tuser  = 1'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_random(input logic mode);
        t_result none;
        none = '0;
        send_word(mode, pick_key(), 1'b0, none);
    endtask

    // Sink: random refusal bursts, plus one long refusal that lets the block
    // back up and stall its input while the sender keeps offering words.
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= 100) begin
                hold_done     = 1'b1;
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Result checker: every accepted output word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("word with nothing expected", m_axis_tdata, '0);
            end else begin
                oldest = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== oldest.key)
                    report_mismatch("key", 48'(m_axis_tdata[31:0]),
                                    48'($unsigned(oldest.key)));
                if (m_axis_tuser !== oldest.status)
                    report_mismatch("status", 48'(m_axis_tuser), 48'(oldest.status));
                if (m_axis_tdata[41:32] !== oldest.count)
                    report_mismatch("count", 48'(m_axis_tdata[41:32]), 48'(oldest.count));
                if (m_axis_tdata[OUT_TDATA_W-1:42] !== '0)
                    report_mismatch("padding", 48'(m_axis_tdata[OUT_TDATA_W-1:42]), '0);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        heap_size      = 0;
        mismatch_count = 0;
        results_seen   = 0;
        calm           = 1'b0;
        hold_done      = 1'b0;
        full_hits      = 0;
        fill_words     = 0;
        wait_cycles    = 0;

        // Remove on an empty heap, then the signed extremes drained in order.
        add_row(MODE_REMOVE, 32'h1234_5678, 1, 32'h0, ST_EMPTY, 0);
        add_row(MODE_INSERT, 32'h0000_0000, 1, 32'h0, ST_OK, 1);
        add_row(MODE_INSERT, 32'h7FFF_FFFF, 1, 32'h0, ST_OK, 2);
        add_row(MODE_INSERT, 32'h8000_0000, 1, 32'h0, ST_OK, 3);
        add_row(MODE_INSERT, 32'hFFFF_FFFF, 1, 32'h0, ST_OK, 4);
        add_row(MODE_INSERT, 32'h0000_0001, 1, 32'h0, ST_OK, 5);
        add_row(MODE_REMOVE, 32'hFFFF_FFFF, 1, 32'h8000_0000, ST_OK, 4);
        add_row(MODE_REMOVE, 32'h0000_0000, 1, 32'hFFFF_FFFF, ST_OK, 3);
        add_row(MODE_REMOVE, 32'hA5A5_A5A5, 1, 32'h0000_0000, ST_OK, 2);
        add_row(MODE_REMOVE, 32'h5A5A_5A5A, 1, 32'h0000_0001, ST_OK, 1);
        add_row(MODE_REMOVE, 32'h0000_0000, 1, 32'h7FFF_FFFF, ST_OK, 0);
        add_row(MODE_REMOVE, 32'h8000_0000, 1, 32'h0, ST_EMPTY, 0);
        // Equal keys and a right child that is strictly smaller than the left.
        add_row(MODE_INSERT, 32'd5, 0, '0, ST_OK, 0);
        add_row(MODE_INSERT, 32'd5, 0, '0, ST_OK, 0);
        add_row(MODE_INSERT, 32'd5, 0, '0, ST_OK, 0);
        add_row(MODE_INSERT, 32'd3, 0, '0, ST_OK, 0);
        add_row(MODE_INSERT, 32'd5, 0, '0, ST_OK, 0);
        add_row(MODE_INSERT, 32'd4, 0, '0, ST_OK, 0);
        add_row(MODE_INSERT, 32'd2, 0, '0, ST_OK, 0);
        add_row(MODE_INSERT, 32'h7FFF_FFFF, 0, '0, ST_OK, 0);
        add_row(MODE_REMOVE, 32'd0, 0, '0, ST_OK, 0);
        add_row(MODE_REMOVE, 32'd0, 0, '0, ST_OK, 0);
        add_row(MODE_REMOVE, 32'd0, 0, '0, ST_OK, 0);
        add_row(MODE_REMOVE, 32'd0, 0, '0, ST_OK, 0);
        add_row(MODE_REMOVE, 32'd0, 0, '0, ST_OK, 0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].mode, directed_rows[i].key,
                      directed_rows[i].known, directed_rows[i].want);
        end

        // Sender stops until the block has handed back every result.
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);

        // Churn a small heap so that removes on an empty heap keep happening.
        repeat (30) begin
            send_random(($urandom_range(0, 1) != 0) ? MODE_REMOVE : MODE_INSERT);
        end

        // Mostly inserts until the heap is full and several inserts are dropped.
        while (full_hits < 8 && fill_words < FILL_CAP) begin
            if ($urandom_range(0, 99) == 0) begin
                send_random(MODE_REMOVE);
            end else begin
                if (heap_size == MAX_KEYS) full_hits++;
                send_random(MODE_INSERT);
            end
            fill_words++;
        end

        // Back-to-back traffic on both sides, mostly removes.
        calm = 1'b1;
        repeat (30) begin
            send_random(($urandom_range(0, 3) != 0) ? MODE_REMOVE : MODE_INSERT);
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 48'(pending_results.size()), '0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
